>>> src/lphs_pkg.sv
// shared types, codes and microcode table of the linear-probe hash set
`timescale 1ns / 1ps

package lphs_pkg;

   // default geometry
   localparam int SLOTS_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;

   // port widths
   localparam int CMD_W        = 2;
   localparam int REQ_KEY_W    = 32;
   localparam int STATUS_W     = 2;
   localparam int RSP_SLOT_W   = 4;
   localparam int RSP_COUNT_W  = 5;
   localparam int MAX_W        = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // load limit after reset: seven tenths of the default table
   localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = MAX_W'(SLOTS_DEFAULT * 7 / 10);

   // register index, taken from paddr above the byte offset
   localparam logic REG_MAX_ENTRIES = 1'b0;

   // bits of the key folded into the home slot per cycle
   localparam int HASH_DIGIT_W = 8;

   // commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // slot marks
   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_DELETED = 2'd1;
   localparam logic [1:0] MARK_USED    = 2'd2;

   // microprogram steps
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_CLEAR  = 3'd0;
   localparam logic [PC_W-1:0] STEP_IDLE   = 3'd1;
   localparam logic [PC_W-1:0] STEP_HASH   = 3'd2;
   localparam logic [PC_W-1:0] STEP_PROBE  = 3'd3;
   localparam logic [PC_W-1:0] STEP_WAIT   = 3'd4;
   localparam logic [PC_W-1:0] STEP_COMMIT = 3'd5;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS     = 3'd0;
   localparam logic [COND_W-1:0] COND_CLR_MORE   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ     = 3'd2;
   localparam logic [COND_W-1:0] COND_HASH_BUSY  = 3'd3;
   localparam logic [COND_W-1:0] COND_PROBE_MORE = 3'd4;
   localparam logic [COND_W-1:0] COND_RSP_FULL   = 3'd5;

   // datapath actions of one control word
   typedef struct packed {
      logic clear;
      logic take;
      logic home;
      logic probe;
      logic commit;
   } ctl_type;

   // datapath flags tested by jumps
   typedef struct packed {
      logic clr_more;
      logic no_req;
      logic hash_busy;
      logic probe_more;
      logic rsp_full;
   } cond_type;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
      ctl_type           act;
   } uword_type;

   // control store: jump to target when cond holds, else fall through
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type uw;
      uw = '0;
      case (pc)
         STEP_CLEAR: begin
            uw.act.clear = 1'b1;
            uw.cond      = COND_CLR_MORE;
            uw.target    = STEP_CLEAR;
         end
         STEP_IDLE: begin
            uw.act.take = 1'b1;
            uw.cond     = COND_NO_REQ;
            uw.target   = STEP_IDLE;
         end
         STEP_HASH: begin
            uw.act.home = 1'b1;
            uw.cond     = COND_HASH_BUSY;
            uw.target   = STEP_HASH;
         end
         STEP_PROBE: begin
            uw.act.probe = 1'b1;
            uw.cond      = COND_PROBE_MORE;
            uw.target    = STEP_PROBE;
         end
         STEP_WAIT: begin
            uw.cond   = COND_RSP_FULL;
            uw.target = STEP_WAIT;
         end
         STEP_COMMIT: begin
            uw.act.commit = 1'b1;
            uw.cond       = COND_ALWAYS;
            uw.target     = STEP_IDLE;
         end
         default: begin
            uw.cond   = COND_ALWAYS;
            uw.target = STEP_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

>>> src/lphs_hash.sv
// home slot unit: key modulo slot count, a few key bits per cycle
`timescale 1ns / 1ps

module lphs_hash #(
   parameter int SLOTS     = lphs_pkg::SLOTS_DEFAULT,
   parameter int KEY_WIDTH = lphs_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [((KEY_WIDTH < lphs_pkg::REQ_KEY_W) ? KEY_WIDTH
                  : lphs_pkg::REQ_KEY_W)-1:0]    key,
   output logic                                 busy,
   output logic [$clog2(SLOTS)-1:0]             home
);

   localparam int KW     = (KEY_WIDTH < lphs_pkg::REQ_KEY_W) ? KEY_WIDTH : lphs_pkg::REQ_KEY_W;
   localparam int DIG    = lphs_pkg::HASH_DIGIT_W;
   localparam int STEPS  = (KW + DIG - 1) / DIG;
   localparam int PAD_W  = STEPS * DIG;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam int IDX_W  = $clog2(SLOTS);

   logic [PAD_W-1:0]  sh_ff, sh_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W:0]    fold;

   // remainder update over one digit, msb first
   always_comb begin
      fold = {1'b0, rem_ff};
      for (int i = 0; i < DIG; i++) begin
         fold = {fold[IDX_W-1:0], sh_ff[PAD_W-1-i]};
         if (fold >= (IDX_W+1)'(SLOTS)) begin
            fold = fold - (IDX_W+1)'(SLOTS);
         end
      end
   end

   always_comb begin
      sh_in  = sh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         sh_in  = PAD_W'(key);
         rem_in = '0;
         cnt_in = STEP_W'(STEPS);
      end else if (cnt_ff != '0) begin
         sh_in  = sh_ff << DIG;
         rem_in = fold[IDX_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign busy = (cnt_ff != '0);
   assign home = rem_ff;

endmodule

>>> src/lphs_sequencer.sv
// microprogram counter and control store lookup
`timescale 1ns / 1ps

module lphs_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  lphs_pkg::cond_type cond,
   output lphs_pkg::ctl_type  ctl
);

   logic [lphs_pkg::PC_W-1:0] pc_ff, pc_in;
   lphs_pkg::uword_type       uw;
   logic                      jump;

   assign uw  = lphs_pkg::ucode(pc_ff);
   assign ctl = uw.act;

   always_comb begin
      case (uw.cond)
         lphs_pkg::COND_ALWAYS:     jump = 1'b1;
         lphs_pkg::COND_CLR_MORE:   jump = cond.clr_more;
         lphs_pkg::COND_NO_REQ:     jump = cond.no_req;
         lphs_pkg::COND_HASH_BUSY:  jump = cond.hash_busy;
         lphs_pkg::COND_PROBE_MORE: jump = cond.probe_more;
         lphs_pkg::COND_RSP_FULL:   jump = cond.rsp_full;
         default:                   jump = 1'b0;
      endcase
      pc_in = jump ? uw.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= lphs_pkg::STEP_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> src/lphs_datapath.sv
// slot memory, probe pointer, entry count and result registers
`timescale 1ns / 1ps

module lphs_datapath #(
   parameter int SLOTS     = lphs_pkg::SLOTS_DEFAULT,
   parameter int KEY_WIDTH = lphs_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lphs_pkg::ctl_type                   ctl,
   input  logic                                accept,
   input  logic [lphs_pkg::CMD_W-1:0]          cmd,
   input  logic [KEY_WIDTH-1:0]                key,
   input  logic [$clog2(SLOTS)-1:0]            home,
   input  logic                                hash_busy,
   input  logic [lphs_pkg::MAX_W-1:0]          max_entries,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [lphs_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lphs_pkg::RSP_SLOT_W-1:0]     rsp_slot,
   output logic [lphs_pkg::RSP_COUNT_W-1:0]    rsp_count,
   output lphs_pkg::cond_type                  cond
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int MW    = KEY_WIDTH + 2;
   localparam int XW    = CNT_W + lphs_pkg::MAX_W;

   logic [MW-1:0] mem [SLOTS];
   logic [MW-1:0] rd_ff;
   logic          we;
   logic [MW-1:0] wd;

   logic [IDX_W-1:0]              pos_ff, pos_in, pos_next;
   logic [IDX_W-1:0]              n_ff, n_in;
   logic [lphs_pkg::CMD_W-1:0]    cmd_ff;
   logic [KEY_WIDTH-1:0]          key_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [lphs_pkg::STATUS_W-1:0] res_ff, res_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lphs_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [lphs_pkg::RSP_SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [lphs_pkg::RSP_COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [1:0]                    mark;
   logic                          last, at_limit, stop, ok;
   logic [lphs_pkg::STATUS_W-1:0] verdict;
   logic [XW-1:0]                 count_x, max_x;
   logic [IDX_W+lphs_pkg::RSP_SLOT_W-1:0]  pos_x;
   logic [CNT_W+lphs_pkg::RSP_COUNT_W-1:0] count_out_x;

   assign mark     = rd_ff[MW-1 -: 2];
   assign last     = (n_ff == IDX_W'(SLOTS - 1));
   assign pos_next = (pos_ff == IDX_W'(SLOTS - 1)) ? '0 : pos_ff + 1'b1;
   assign count_x  = {{lphs_pkg::MAX_W{1'b0}}, count_ff};
   assign max_x    = {{CNT_W{1'b0}}, max_entries};
   assign at_limit = (count_x >= max_x) || (count_ff >= CNT_W'(SLOTS));

   // outcome of the slot under the probe pointer
   always_comb begin
      stop    = 1'b1;
      verdict = lphs_pkg::ST_NOT_FOUND;
      case (cmd_ff)
         lphs_pkg::CMD_INSERT: begin
            if (at_limit) begin
               verdict = lphs_pkg::ST_FULL;
            end else if (mark != lphs_pkg::MARK_USED) begin
               verdict = lphs_pkg::ST_OK;
            end else if (last) begin
               verdict = lphs_pkg::ST_FULL;
            end else begin
               stop = 1'b0;
            end
         end
         lphs_pkg::CMD_REMOVE, lphs_pkg::CMD_FIND: begin
            if (mark == lphs_pkg::MARK_EMPTY) begin
               verdict = lphs_pkg::ST_NOT_FOUND;
            end else if (mark == lphs_pkg::MARK_USED && rd_ff[KEY_WIDTH-1:0] == key_ff) begin
               verdict = lphs_pkg::ST_OK;
            end else if (!last) begin
               stop = 1'b0;
            end
         end
         default: begin
            verdict = lphs_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   assign ok          = (res_ff == lphs_pkg::ST_OK);
   assign pos_x       = {{lphs_pkg::RSP_SLOT_W{1'b0}}, pos_ff};
   assign count_out_x = {{lphs_pkg::RSP_COUNT_W{1'b0}}, count_in};

   always_comb begin
      pos_in        = pos_ff;
      n_in          = n_ff;
      res_in        = res_ff;
      count_in      = count_ff;
      we            = 1'b0;
      wd            = {lphs_pkg::MARK_EMPTY, {KEY_WIDTH{1'b0}}};
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (ctl.clear) begin
         we     = 1'b1;
         pos_in = pos_next;
      end
      if (ctl.home) begin
         pos_in = home;
         n_in   = '0;
      end
      if (ctl.probe) begin
         if (stop) begin
            res_in = verdict;
         end else begin
            pos_in = pos_next;
            n_in   = n_ff + 1'b1;
         end
      end
      if (ctl.commit) begin
         if (ok && cmd_ff == lphs_pkg::CMD_INSERT) begin
            we       = 1'b1;
            wd       = {lphs_pkg::MARK_USED, key_ff};
            count_in = count_ff + 1'b1;
         end else if (ok && cmd_ff == lphs_pkg::CMD_REMOVE) begin
            we = 1'b1;
            wd = {lphs_pkg::MARK_DELETED, key_ff};
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_ff;
         rsp_slot_in   = ok ? pos_x[lphs_pkg::RSP_SLOT_W-1:0] : '0;
         rsp_count_in  = count_out_x[lphs_pkg::RSP_COUNT_W-1:0];
      end
   end

   // slot memory with one write port and one read port; read follows the next probe address
   always_ff @(posedge clock) begin
      if (we) begin
         mem[pos_ff] <= wd;
      end
      rd_ff <= mem[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      if (accept) begin
         cmd_ff <= cmd;
         key_ff <= key;
      end
   end

   assign cond.clr_more   = (pos_ff != IDX_W'(SLOTS - 1));
   assign cond.no_req     = !accept;
   assign cond.hash_busy  = hash_busy;
   assign cond.probe_more = !stop;
   assign cond.rsp_full   = rsp_valid_ff && rsp_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

>>> src/linear_probe_hash_set.sv
// top level of the linear-probe hash set: config register and unit wiring
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   req_cmd, req_key
//   rsp       out        rsp_valid / rsp_stall   rsp_status, rsp_slot, rsp_count
//   csr       in/out     psel, penable, pready   paddr, pwrite, pwdata, prdata
//
// a request is taken, its home slot is found by the 8-bit-per-cycle home slot unit,
// the probe loop reads one slot per cycle (1..SLOTS slots probed) from the slot memory,
// which has one write and one read port, and the commit step answers and writes back.
// after reset a clearing pass marks every slot empty; no request is taken meanwhile,
// config writes are.
// a stalled result holds the sequencer before the write-back; one request is in work at a time.
`timescale 1ns / 1ps

module linear_probe_hash_set #(
   parameter int SLOTS     = lphs_pkg::SLOTS_DEFAULT,
   parameter int KEY_WIDTH = lphs_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lphs_pkg::CMD_W-1:0]          req_cmd,
   input  logic [lphs_pkg::REQ_KEY_W-1:0]      req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lphs_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lphs_pkg::RSP_SLOT_W-1:0]     rsp_slot,
   output logic [lphs_pkg::RSP_COUNT_W-1:0]    rsp_count,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lphs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lphs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lphs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int KW    = (KEY_WIDTH < lphs_pkg::REQ_KEY_W) ? KEY_WIDTH : lphs_pkg::REQ_KEY_W;
   localparam int IDX_W = $clog2(SLOTS);

   lphs_pkg::ctl_type  ctl;
   lphs_pkg::cond_type cond;

   logic                         accept;
   logic                         hash_busy;
   logic [IDX_W-1:0]             home;
   logic [KEY_WIDTH-1:0]         key_ext;
   logic [lphs_pkg::MAX_W-1:0]   max_ff, max_in;
   logic                         csr_wr;

   // key cut or zero-extended to KEY_WIDTH bits
   generate
      if (KEY_WIDTH <= lphs_pkg::REQ_KEY_W) begin : g_key_narrow
         assign key_ext = req_key[KEY_WIDTH-1:0];
      end else begin : g_key_wide
         assign key_ext = KEY_WIDTH'(req_key);
      end
   endgenerate

   assign req_stall = !ctl.take;
   assign accept    = req_valid && ctl.take;

   // load limit register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == lphs_pkg::REG_MAX_ENTRIES);
   assign max_in = csr_wr ? pwdata[lphs_pkg::MAX_W-1:0] : max_ff;
   assign prdata = (paddr[2] == lphs_pkg::REG_MAX_ENTRIES) ?
                   lphs_pkg::CSR_DATA_W'(max_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= lphs_pkg::MAX_ENTRIES_RESET;
      end else begin
         max_ff <= max_in;
      end
   end

   lphs_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl)
   );

   lphs_hash #(
      .SLOTS     (SLOTS),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (req_key[KW-1:0]),
      .busy  (hash_busy),
      .home  (home)
   );

   lphs_datapath #(
      .SLOTS     (SLOTS),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .accept      (accept),
      .cmd         (req_cmd),
      .key         (key_ext),
      .home        (home),
      .hash_busy   (hash_busy),
      .max_entries (max_ff),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .rsp_count   (rsp_count),
      .cond        (cond)
   );

   // one request in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while previous one in work");

   // no request during the clearing pass
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // failed operations report slot zero
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lphs_pkg::ST_OK) |-> (rsp_slot == '0))
      else $error("nonzero slot on failed result");

   // hash unit idle whenever a new request can be taken
   a_hash_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.take |-> !hash_busy)
      else $error("hash unit busy in idle step");

endmodule

>>> sim/tb_top.sv
// testbench for the linear-probe hash set: shadow table, request driver and result checker
`timescale 1ns / 1ps

typedef struct packed {
   logic [lphs_pkg::STATUS_W-1:0]    status;
   logic [lphs_pkg::RSP_SLOT_W-1:0]  slot;
   logic [lphs_pkg::RSP_COUNT_W-1:0] count;
} hash_reply_type;

// shadow copy of the table; predicts one reply per request and checks replies in order
class hash_set_shadow;
   logic [1:0]                     mark [lphs_pkg::SLOTS_DEFAULT];
   logic [lphs_pkg::REQ_KEY_W-1:0] stored_key [lphs_pkg::SLOTS_DEFAULT];
   int unsigned                    entry_count;
   int unsigned                    load_limit;
   hash_reply_type                 owed_replies [$];
   int unsigned                    mismatches;
   int unsigned                    replies_seen;
   int unsigned                    status_tally [4];

   function new();
      foreach (mark[i]) begin
         mark[i]       = lphs_pkg::MARK_EMPTY;
         stored_key[i] = '0;
      end
      entry_count  = 0;
      load_limit   = 32'(lphs_pkg::MAX_ENTRIES_RESET);
      mismatches   = 0;
      replies_seen = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
   endfunction

   function void set_limit(input logic [lphs_pkg::MAX_W-1:0] value);
      load_limit = 32'(value);
   endfunction

   function int home_slot(input logic [lphs_pkg::REQ_KEY_W-1:0] key);
      return int'(key % lphs_pkg::REQ_KEY_W'(lphs_pkg::SLOTS_DEFAULT));
   endfunction

   // first used slot holding the key; stops at an empty slot or after one wrap
   function bit locate(input logic [lphs_pkg::REQ_KEY_W-1:0] key, output int where);
      int pos;
      pos   = home_slot(key);
      where = 0;
      for (int n = 0; n < lphs_pkg::SLOTS_DEFAULT; n++) begin
         if (mark[pos] == lphs_pkg::MARK_EMPTY) return 1'b0;
         if (mark[pos] == lphs_pkg::MARK_USED && stored_key[pos] == key) begin
            where = pos;
            return 1'b1;
         end
         pos = (pos + 1) % lphs_pkg::SLOTS_DEFAULT;
      end
      return 1'b0;
   endfunction

   function void note_request(input logic [lphs_pkg::CMD_W-1:0] cmd,
                              input logic [lphs_pkg::REQ_KEY_W-1:0] key);
      hash_reply_type r;
      int             pos;
      bit             open_found;
      r.status = lphs_pkg::ST_NOT_FOUND;
      r.slot   = '0;
      case (cmd)
         lphs_pkg::CMD_INSERT: begin
            if (entry_count >= load_limit || entry_count >= lphs_pkg::SLOTS_DEFAULT) begin
               r.status = lphs_pkg::ST_FULL;
            end else begin
               pos        = home_slot(key);
               open_found = 1'b0;
               for (int n = 0; n < lphs_pkg::SLOTS_DEFAULT; n++) begin
                  if (!open_found) begin
                     if (mark[pos] != lphs_pkg::MARK_USED) open_found = 1'b1;
                     else pos = (pos + 1) % lphs_pkg::SLOTS_DEFAULT;
                  end
               end
               if (open_found) begin
                  mark[pos]       = lphs_pkg::MARK_USED;
                  stored_key[pos] = key;
                  entry_count++;
                  r.status = lphs_pkg::ST_OK;
                  r.slot   = lphs_pkg::RSP_SLOT_W'(pos);
               end else begin
                  r.status = lphs_pkg::ST_FULL;
               end
            end
         end
         lphs_pkg::CMD_REMOVE: begin
            if (locate(key, pos)) begin
               mark[pos] = lphs_pkg::MARK_DELETED;
               if (entry_count > 0) entry_count--;
               r.status = lphs_pkg::ST_OK;
               r.slot   = lphs_pkg::RSP_SLOT_W'(pos);
            end
         end
         lphs_pkg::CMD_FIND: begin
            if (locate(key, pos)) begin
               r.status = lphs_pkg::ST_OK;
               r.slot   = lphs_pkg::RSP_SLOT_W'(pos);
            end
         end
         default: ;
      endcase
      r.count = lphs_pkg::RSP_COUNT_W'(entry_count);
      owed_replies.push_back(r);
   endfunction

   function void check_response(input logic [lphs_pkg::STATUS_W-1:0] status,
                                input logic [lphs_pkg::RSP_SLOT_W-1:0] slot,
                                input logic [lphs_pkg::RSP_COUNT_W-1:0] count);
      hash_reply_type want;
      replies_seen++;
      if (owed_replies.size() == 0) begin
         $error("unexpected result: status %0d slot %0d count %0d", status, slot, count);
         mismatches++;
         return;
      end
      want = owed_replies.pop_front();
      status_tally[want.status]++;
      if (status !== want.status) begin
         $error("status mismatch: expected %0d, actual %0d", want.status, status);
         mismatches++;
      end
      if (slot !== want.slot) begin
         $error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
         mismatches++;
      end
      if (count !== want.count) begin
         $error("count mismatch: expected %0d, actual %0d", want.count, count);
         mismatches++;
      end
   endfunction
endclass

module tb_top;

   localparam logic [lphs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 30;
   localparam int POOL_SIZE = 10;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [lphs_pkg::CMD_W-1:0]       req_cmd = lphs_pkg::CMD_INSERT;
   logic [lphs_pkg::REQ_KEY_W-1:0]   req_key = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [lphs_pkg::STATUS_W-1:0]    rsp_status;
   logic [lphs_pkg::RSP_SLOT_W-1:0]  rsp_slot;
   logic [lphs_pkg::RSP_COUNT_W-1:0] rsp_count;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [lphs_pkg::CSR_ADDR_W-1:0]  paddr = '0;
   logic [lphs_pkg::CSR_DATA_W-1:0]  pwdata = '0;
   logic [lphs_pkg::CSR_DATA_W-1:0]  prdata;
   logic                             pready;

   hash_set_shadow book = new();
   bit             quiet = 1'b0;
   int unsigned    requests_sent = 0;
   int unsigned    limit_settings = 1;

   linear_probe_hash_set u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot),
      .rsp_count  (rsp_count),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure in bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_response(rsp_status, rsp_slot, rsp_count);
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic [lphs_pkg::CMD_W-1:0] cmd,
                               input logic [lphs_pkg::REQ_KEY_W-1:0] key);
      if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 8)) @(negedge clock);
      req_cmd   = cmd;
      req_key   = key;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      book.note_request(cmd, key);
      requests_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain_results();
      while (book.owed_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_limit(input int unsigned value);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {lphs_pkg::REG_MAX_ENTRIES, 2'b00};
      pwdata  = lphs_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      book.set_limit(pwdata[lphs_pkg::MAX_W-1:0]);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      limit_settings++;
   endtask

   // keys come mostly from a small pool whose homes crowd around the wrap point
   task automatic run_phase(input int unsigned limit, input int unsigned items);
      logic [lphs_pkg::REQ_KEY_W-1:0] pool [POOL_SIZE];
      logic [lphs_pkg::CMD_W-1:0]     cmd;
      logic [lphs_pkg::REQ_KEY_W-1:0] key;
      int unsigned                    pick;
      write_limit(limit);
      foreach (pool[i]) begin
         pool[i] = $urandom;
         if ($urandom_range(0, 2) != 0) pool[i][3:0] = 4'($urandom_range(14, 17) % 16);
      end
      for (int unsigned i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) cmd = lphs_pkg::CMD_INSERT;
         else if (pick < 65) cmd = lphs_pkg::CMD_REMOVE;
         else if (pick < 95) cmd = lphs_pkg::CMD_FIND;
         else cmd = CMD_UNUSED;
         if ($urandom_range(0, 4) == 0) key = $urandom;
         else key = pool[$urandom_range(0, POOL_SIZE - 1)];
         // hold off until the block has answered everything
         if (i == items / 2) drain_results();
         send_request(cmd, key);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // collisions, duplicates, tombstones and wrap-around at the reset load limit
      send_request(lphs_pkg::CMD_INSERT, 32'h0000_0000);
      send_request(lphs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
      send_request(lphs_pkg::CMD_INSERT, 32'h0000_0010);
      send_request(lphs_pkg::CMD_INSERT, 32'h0000_0000);
      send_request(lphs_pkg::CMD_FIND,   32'h0000_0000);
      send_request(lphs_pkg::CMD_REMOVE, 32'h0000_0000);
      send_request(lphs_pkg::CMD_FIND,   32'h0000_0000);
      send_request(lphs_pkg::CMD_FIND,   32'h0000_0010);
      send_request(lphs_pkg::CMD_REMOVE, 32'h0000_0020);
      send_request(lphs_pkg::CMD_FIND,   32'h1234_5677);
      send_request(CMD_UNUSED,           32'hAAAA_5555);
      send_request(lphs_pkg::CMD_INSERT, 32'h0000_001F);
      send_request(lphs_pkg::CMD_FIND,   32'h0000_001F);
      send_request(lphs_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
      send_request(lphs_pkg::CMD_FIND,   32'h0000_001F);
      // fill up to the load limit and one past it
      for (int i = 0; i < 9; i++) send_request(lphs_pkg::CMD_INSERT, 32'h5A5A_0000 | 32'(i * 5));

      run_phase(lphs_pkg::SLOTS_DEFAULT, 260);
      run_phase(31, 260);
      run_phase(0, 40);
      run_phase(1, 120);
      run_phase($urandom_range(2, 15), 250);
      drain_results();
      quiet = 1'b1;
      run_phase(32'(lphs_pkg::MAX_ENTRIES_RESET), 200);

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d requests under %0d load-limit settings, %0d results checked.",
               requests_sent, limit_settings, book.replies_seen);
      $display("Outcomes: %0d ok, %0d not found, %0d full.",
               book.status_tally[lphs_pkg::ST_OK], book.status_tally[lphs_pkg::ST_NOT_FOUND],
               book.status_tally[lphs_pkg::ST_FULL]);
      if (book.mismatches == 0 && book.owed_replies.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
